// ===== sv/unsigned_to_ascii_radix_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef UNSIGNED_TO_ASCII_RADIX_MACROS_SVH
`define UNSIGNED_TO_ASCII_RADIX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// The consequent must hold in the cycle after the antecedent.
`define UAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ===== sv/uar_pkg.sv =====
package uar_pkg;

    localparam int ValueWidth       = 32;
    localparam int CmdWidth         = 2;
    localparam int CharWidth        = 7;
    localparam int ValueBitsDefault = 32;
    localparam int QueueDepth       = 2;
    localparam int OctShift         = 3;
    localparam int HexShift         = 4;

    // Radix select codes as they arrive on the input.
    localparam logic [CmdWidth-1:0] CmdDec   = 2'd0;
    localparam logic [CmdWidth-1:0] CmdOct   = 2'd1;
    localparam logic [CmdWidth-1:0] CmdHexLo = 2'd2;
    localparam logic [CmdWidth-1:0] CmdHexUp = 2'd3;

    localparam logic [3:0] DigitTen = 4'd10;

    localparam logic [CharWidth-1:0] CharZero   = 7'h30;
    localparam logic [CharWidth-1:0] CharNine   = 7'h39;
    localparam logic [CharWidth-1:0] CharLowerA = 7'h61;
    localparam logic [CharWidth-1:0] CharLowerF = 7'h66;
    localparam logic [CharWidth-1:0] CharUpperA = 7'h41;
    localparam logic [CharWidth-1:0] CharUpperF = 7'h46;

    typedef enum logic [1:0] {
        RADIX_DEC    = 2'd0,
        RADIX_OCT    = 2'd1,
        RADIX_HEX_LO = 2'd2,
        RADIX_HEX_UP = 2'd3
    } t_radix;

    // Only the low bits of the input word that the configured width keeps matter.
    function automatic int eff_bits(input int value_bits);
        return (value_bits < ValueWidth) ? value_bits : ValueWidth;
    endfunction

    function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] digit,
                                                        input t_radix radix);
        if (digit < DigitTen) begin
            return CharZero + CharWidth'(digit);
        end else if (radix == RADIX_HEX_UP) begin
            return CharUpperA + CharWidth'(digit - DigitTen);
        end else begin
            return CharLowerA + CharWidth'(digit - DigitTen);
        end
    endfunction

endpackage

// ===== sv/uar_in_if.sv =====
interface uar_in_if;
    import uar_pkg::*;

    logic                valid;
    logic                ready;
    logic [ValueWidth-1:0] value;
    logic [CmdWidth-1:0]   command;

    modport source (output valid, output value, output command, input ready);
    modport sink   (input valid, input value, input command, output ready);
endinterface

// ===== sv/uar_out_if.sv =====
interface uar_out_if;
    import uar_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== sv/unsigned_to_ascii_radix.sv =====
// Channel   Dir  Beat contents              Handshake
// i_in      in   value[31:0], command[1:0]  valid/ready, one number per beat
// o_out     out  character[6:0], last       valid/ready, one character per beat
//
// Octal and hex numbers give up one digit per pass through ST_DIG; a decimal digit first
// goes through the reciprocal multiplier (ST_MUL) and then the remainder step (ST_DIG).
// The characters then leave one per cycle while the output takes them.
// Reset is synchronous and active low; it empties the queue and idles the converter.
// Either side may stall at any time: the two-entry queue keeps accepting numbers, until
// it is full, while the converter waits for the output to be taken.
module unsigned_to_ascii_radix #(
    parameter int VALUE_BITS = uar_pkg::ValueBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uar_in_if.sink    i_in,
    uar_out_if.source o_out
);
    import uar_pkg::*;

    localparam int EffBits = eff_bits(VALUE_BITS);

    // Numbers waiting between the front and the converter.
    logic               job_valid;
    logic               job_ready;
    logic [EffBits-1:0] job_value;
    t_radix             job_radix;

    // The front masks the value to the configured width, turns the command into a
    // radix and holds up to two numbers, so input beats are taken while the converter
    // is busy or its output is stalled.
    uar_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_value (job_value),
        .o_job_radix (job_radix)
    );

    // The converter splits off digits least significant first onto a small stack and
    // then pops them most significant first. Zero still yields one digit, '0'. A new
    // number is picked up in the same cycle the last character of the previous one
    // leaves.
    uar_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_value (job_value),
        .i_job_radix (job_radix),
        .o_out       (o_out)
    );

endmodule

// ===== sv/uar_front.sv =====
module uar_front #(
    parameter int VALUE_BITS = uar_pkg::ValueBitsDefault
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    uar_in_if.sink                                     i_in,
    output logic                                       o_job_valid,
    input  logic                                       i_job_ready,
    output logic [uar_pkg::eff_bits(VALUE_BITS)-1:0]   o_job_value,
    output uar_pkg::t_radix                            o_job_radix
);
    import uar_pkg::*;

    localparam int EffBits = eff_bits(VALUE_BITS);
    localparam int PtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW    = $clog2(QueueDepth + 1);

    logic [EffBits-1:0] r_q_value [QueueDepth];
    t_radix             r_q_radix [QueueDepth];
    logic [PtrW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]    r_count, n_count;
    logic               push;
    logic               pop;
    t_radix             in_radix;

    // Classify the command into a radix.
    always_comb begin
        case (i_in.command)
            CmdDec:   in_radix = RADIX_DEC;
            CmdOct:   in_radix = RADIX_OCT;
            CmdHexLo: in_radix = RADIX_HEX_LO;
            CmdHexUp: in_radix = RADIX_HEX_UP;
            default:  in_radix = RADIX_DEC;
        endcase
    end

    assign i_in.ready  = (r_count != CntW'(QueueDepth));
    assign o_job_valid = (r_count != '0);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = o_job_valid && i_job_ready;
    assign o_job_value = r_q_value[r_rd_ptr];
    assign o_job_radix = r_q_radix[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wr_ptr] <= i_in.value[EffBits-1:0];
            r_q_radix[r_wr_ptr] <= in_radix;
        end
    end

endmodule

// ===== sv/uar_back.sv =====
module uar_back #(
    parameter int VALUE_BITS = uar_pkg::ValueBitsDefault
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_job_valid,
    output logic                                     o_job_ready,
    input  logic [uar_pkg::eff_bits(VALUE_BITS)-1:0] i_job_value,
    input  uar_pkg::t_radix                          i_job_radix,
    uar_out_if.source                                o_out
);
    import uar_pkg::*;

    localparam int EffBits   = eff_bits(VALUE_BITS);
    localparam int ProdBits  = 2 * EffBits;
    localparam int Shift     = EffBits + 3;
    localparam int NumDigits = (EffBits + 2) / 3;
    localparam int CntW      = $clog2(NumDigits + 1);
    // Reciprocal of ten, rounded up; exact for every EffBits-wide dividend.
    localparam longint unsigned RecipFull = ((64'd1 << Shift) + 64'd9) / 64'd10;
    localparam logic [EffBits-1:0] Recip  = EffBits'(RecipFull);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIG  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic [EffBits-1:0]   r_val, n_val;
    t_radix               r_radix, n_radix;
    logic [ProdBits-1:0]  r_prod, n_prod;
    logic [CharWidth-1:0] r_stack [NumDigits];
    logic [CharWidth-1:0] n_stack [NumDigits];

    logic [EffBits-4:0]   quot;
    logic [3:0]           quot_ten_lo;
    logic [3:0]           dig;
    logic [EffBits-1:0]   dig_next;
    logic                 last_fire;
    logic                 job_take;

    assign quot        = r_prod[ProdBits-1:Shift];
    // Only the low nibble of 10*q is needed: the remainder is below ten.
    assign quot_ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};

    always_comb begin
        case (r_radix)
            RADIX_DEC: begin
                dig      = r_val[3:0] - quot_ten_lo;
                dig_next = EffBits'(quot);
            end
            RADIX_OCT: begin
                dig      = {1'b0, r_val[2:0]};
                dig_next = r_val >> OctShift;
            end
            RADIX_HEX_LO, RADIX_HEX_UP: begin
                dig      = r_val[3:0];
                dig_next = r_val >> HexShift;
            end
            default: begin
                dig      = '0;
                dig_next = '0;
            end
        endcase
    end

    assign last_fire   = (r_state == ST_OUT) && o_out.ready && (r_cnt == CntW'(1));
    assign o_job_ready = (r_state == ST_IDLE) || last_fire;
    assign job_take    = o_job_ready && i_job_valid;

    assign o_out.valid     = (r_state == ST_OUT);
    assign o_out.character = r_stack[0];
    assign o_out.last      = (r_cnt == CntW'(1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_val   = r_val;
        n_radix = r_radix;
        n_prod  = r_prod;
        n_stack = r_stack;
        case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_MUL: begin
                n_prod  = ProdBits'(r_val) * ProdBits'(Recip);
                n_state = ST_DIG;
            end
            ST_DIG: begin
                // Digits come least significant first; push them onto the stack.
                n_stack[0] = digit_char(dig, r_radix);
                for (int i = 1; i < NumDigits; i++) begin
                    n_stack[i] = r_stack[i-1];
                end
                n_cnt = r_cnt + 1'b1;
                if (dig_next == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_val   = dig_next;
                    n_state = (r_radix == RADIX_DEC) ? ST_MUL : ST_DIG;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    for (int i = 0; i < NumDigits - 1; i++) begin
                        n_stack[i] = r_stack[i+1];
                    end
                    n_cnt = r_cnt - 1'b1;
                    if (last_fire) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (job_take) begin
            n_val   = i_job_value;
            n_radix = i_job_radix;
            n_cnt   = '0;
            n_state = (i_job_radix == RADIX_DEC) ? ST_MUL : ST_DIG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_radix <= n_radix;
        r_prod  <= n_prod;
        r_stack <= n_stack;
    end

endmodule

// ===== sv/uar_chk.sv =====
`include "unsigned_to_ascii_radix_macros.svh"

module uar_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [uar_pkg::CharWidth-1:0] i_out_character,
    input logic                          i_out_last
);
    import uar_pkg::*;

    logic               r_first_beat;
    logic               is_digit;
    logic               out_stall;
    logic [CharWidth:0] out_beat;
    logic               lead_zero;

    // Set while the next character to leave opens a new number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_beat <= 1'b1;
        end else if (i_out_valid && i_out_ready) begin
            r_first_beat <= i_out_last;
        end
    end

    assign is_digit = (i_out_character >= CharZero && i_out_character <= CharNine) ||
                      (i_out_character >= CharLowerA && i_out_character <= CharLowerF) ||
                      (i_out_character >= CharUpperA && i_out_character <= CharUpperF);

    // A beat offered but not taken, and the whole beat as one word.
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_beat  = {i_out_character, i_out_last};
    // A '0' that opens a number must be the whole number.
    assign lead_zero = i_out_valid && r_first_beat && (i_out_character == CharZero);

    `UAR_ASSERT_NXT(a_valid_holds, i_clk, i_rst_n, out_stall, i_out_valid)
    `UAR_ASSERT_NXT(a_beat_holds, i_clk, i_rst_n, out_stall, $stable(out_beat))
    `UAR_ASSERT_IMP(a_is_digit, i_clk, i_rst_n, i_out_valid, is_digit)
    `UAR_ASSERT_IMP(a_no_lead_zero, i_clk, i_rst_n, lead_zero, i_out_last)

endmodule

bind unsigned_to_ascii_radix uar_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);

// ===== verif/unsigned_to_ascii_radix_tb.sv =====
// Testbench for the unsigned-to-ASCII radix converter.
//
// Every number sent on the input channel is run through a predictor that
// works out its digit string in the selected radix. That predictor
// yields the ASCII characters, most significant first, with the final
// one flagged as last. These expected characters wait in a queue. Each
// character beat taken from the output channel is checked against the
// oldest one, field by field.
//
// The stimulus starts with hand-picked numbers: zero, the largest value,
// the largest single digit and the smallest two-digit value of each
// radix, both hex letter cases, and a few long decimal and octal strings.
// After that come random numbers whose width is also random, so that
// every string length shows up. They run under three idle patterns on the
// two channels. A long output stall is also applied while numbers keep
// coming in, so the input queue of the block fills up and pushes back.
module unsigned_to_ascii_radix_tb;
    import uar_pkg::*;

    // Generous bound on the whole run.
    localparam int CycleLimit   = 400000;
    localparam int ResetCycles  = 10;
    // Cycles allowed after the last expected character for any stray beat.
    localparam int SettleCycles = 64;
    localparam int RandomCount  = 155;
    localparam int StallCycles  = 300;
    localparam int StallNumbers = 12;

    // One expected character beat on the output channel.
    typedef struct packed {
        logic [CharWidth-1:0] character;
        logic                 last;
    } t_char_beat;

    logic i_clk;
    logic i_rst_n;

    uar_in_if  in_bus ();
    uar_out_if out_bus ();

    unsigned_to_ascii_radix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Characters still owed by the block, oldest first.
    t_char_beat expected_chars[$];

    int error_count;
    int cycle_count;

    // Idle percentages of the two channels, changed between phases.
    int number_gap_pct;
    int char_stall_pct;

    // Remaining cycles of a forced output stall. The receiver counts it down.
    int stall_left;

    // The clock has a period of 20 time units.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("unsigned_to_ascii_radix_tb: done, errors");
        $finish;
    end

    // Predictor: the digits are collected least significant first by repeated
    // division, then queued most significant first. Zero still gives one digit.
    function automatic void predict_ascii_digits(input logic [ValueWidth-1:0] value,
                                                 input t_radix radix);
        logic [ValueWidth-1:0] rest;
        int unsigned           base;
        logic [3:0]            digit;
        logic [CharWidth-1:0]  msd_first[$];
        logic [CharWidth-1:0]  letter_base;

        case (radix)
            RADIX_DEC: base = 10;
            RADIX_OCT: base = 8;
            default:   base = 16;
        endcase
        letter_base = (radix == RADIX_HEX_UP) ? CharUpperA : CharLowerA;
        rest = value;
        do begin
            digit = 4'(rest % base);
            if (digit < 4'd10) begin
                msd_first.push_front(CharZero + CharWidth'(digit));
            end else begin
                msd_first.push_front(letter_base + CharWidth'(digit - 4'd10));
            end
            rest = rest / base;
        end while (rest != 0);
        foreach (msd_first[i]) begin
            expected_chars.push_back('{character: msd_first[i],
                                       last: (i == msd_first.size() - 1)});
        end
    endfunction

    // Sends one number. It starts at a falling edge, may idle first, and then
    // holds the beat until a rising edge sees ready. Valid stays high from one
    // number to the next when no idle cycle falls between them, so it is never
    // dropped and raised within one time step.
    task automatic send_number(input logic [ValueWidth-1:0] value, input t_radix radix);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < number_gap_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.value   <= value;
        in_bus.command <= radix;
        do begin
            @(posedge i_clk);
        end while (!in_bus.ready);
        predict_ascii_digits(value, radix);
    endtask

    // Lowers valid once the sender has nothing more to offer.
    task automatic stop_sending;
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
    endtask

    // A random number of random width, so that every digit count is hit.
    // Now and then the full 32 bits are taken.
    function automatic logic [ValueWidth-1:0] random_value;
        if ($urandom_range(3, 0) == 0) begin
            return $urandom;
        end
        return $urandom >> $urandom_range(ValueWidth - 1, 0);
    endfunction

    // Receiver: decides ready at each falling edge. A forced stall has
    // priority over the random idle pattern.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= ($urandom_range(99, 0) >= char_stall_pct);
            end
        end
    end

    // Checker: every character beat taken is compared with the oldest expected one.
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character beat, expected none, actual %h last %0b",
                         $time, out_bus.character, out_bus.last);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                if (out_bus.character !== want.character) begin
                    $display("%0t: character mismatch, expected %h, actual %h",
                             $time, want.character, out_bus.character);
                    error_count++;
                end
                if (out_bus.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, out_bus.last);
                    error_count++;
                end
            end
        end
    end

    // Edge values of every radix. These cover zero, the largest value, the
    // largest single digit, the first value to need two digits, all hex
    // letters in both cases, and the longest decimal and octal strings.
    task automatic test_directed;
        send_number(32'd0, RADIX_DEC);
        send_number(32'd0, RADIX_OCT);
        send_number(32'd0, RADIX_HEX_LO);
        send_number(32'd0, RADIX_HEX_UP);
        send_number(32'hFFFF_FFFF, RADIX_DEC);
        send_number(32'hFFFF_FFFF, RADIX_OCT);
        send_number(32'hFFFF_FFFF, RADIX_HEX_LO);
        send_number(32'hFFFF_FFFF, RADIX_HEX_UP);
        send_number(32'd1, RADIX_DEC);
        send_number(32'd9, RADIX_DEC);
        send_number(32'd7, RADIX_OCT);
        send_number(32'd15, RADIX_HEX_LO);
        send_number(32'd15, RADIX_HEX_UP);
        send_number(32'd10, RADIX_DEC);
        send_number(32'd8, RADIX_OCT);
        send_number(32'd16, RADIX_HEX_LO);
        send_number(32'hFEDC_BA98, RADIX_HEX_LO);
        send_number(32'hFEDC_BA98, RADIX_HEX_UP);
        send_number(32'h8000_0000, RADIX_OCT);
        send_number(32'h3FFF_FFFF, RADIX_OCT);
        send_number(32'd999_999_999, RADIX_DEC);
        send_number(32'd1_000_000_000, RADIX_DEC);
        stop_sending();
    endtask

    // Random numbers in random radixes under the current idle pattern.
    task automatic test_random_numbers(input int count);
        repeat (count) begin
            send_number(random_value(), t_radix'($urandom_range(3, 0)));
        end
        stop_sending();
    endtask

    // The receiver holds off for a long stretch while numbers keep being
    // offered. The block's input queue fills, and ready on the input must drop
    // until characters drain again. The stall is armed at a rising edge, so
    // the receiver sees it at the next falling edge.
    task automatic test_output_stall;
        @(posedge i_clk);
        stall_left = StallCycles;
        repeat (StallNumbers) begin
            send_number(random_value(), t_radix'($urandom_range(3, 0)));
        end
        stop_sending();
    endtask

    // Waits until every expected character has arrived. A hang here is
    // caught by the watchdog.
    task automatic wait_for_drain;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        error_count    = 0;
        stall_left     = 0;
        number_gap_pct = 0;
        char_stall_pct = 0;
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.value   = '0;
        in_bus.command = RADIX_DEC;

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The sender idles lightly and the receiver heavily.
        number_gap_pct = 24;
        char_stall_pct = 53;
        test_directed();
        test_random_numbers(RandomCount);

        // The pattern is reversed.
        number_gap_pct = 53;
        char_stall_pct = 24;
        test_random_numbers(RandomCount);

        // Neither side idles, apart from one long stall of the receiver.
        number_gap_pct = 0;
        char_stall_pct = 0;
        test_output_stall();
        test_random_numbers(RandomCount);

        wait_for_drain();
        repeat (SettleCycles) @(posedge i_clk);

        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("unsigned_to_ascii_radix_tb: done, clean");
        end else begin
            $display("unsigned_to_ascii_radix_tb: done, errors");
        end
        $finish;
    end

endmodule
